// File: rtl/b2da_pkg.sv
// shared constants, types and power-of-ten table for the binary to decimal ascii converter
`default_nettype none

package b2da_pkg;

	localparam int VAL_W      = 32;
	localparam int NUM_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int IDX_W      = 4;
	localparam int CHAR_W     = 6;
	localparam int MUL_W      = 34;
	localparam int MAX_MULT   = 9;

	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_DIGITS - 1);
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;

	localparam logic [VAL_W-1:0] POW10 [NUM_DIGITS] = '{
		32'd1000000000, 32'd100000000, 32'd10000000, 32'd1000000, 32'd100000,
		32'd10000, 32'd1000, 32'd100, 32'd10, 32'd1
	};

	// decimal digits, index 0 is the most significant
	typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

	// one converted number on its way to the serializer
	typedef struct packed {
		digits_t          digits;
		logic [IDX_W-1:0] lead;
	} b2da_item_t;

	// m times the power of ten for digit position k, wide enough for 9e9
	function automatic logic [MUL_W-1:0] pow10_mult(input int k, input int m);
		return MUL_W'(POW10[k]) * MUL_W'(m);
	endfunction

endpackage

`default_nettype wire

// File: rtl/b2da_digit_pipe.sv
// ten-stage digit extraction pipeline, one decimal digit per stage
`default_nettype none

module b2da_digit_pipe (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire [b2da_pkg::VAL_W-1:0]   value,
	output logic                        out_valid,
	input  wire                         out_ready,
	output b2da_pkg::b2da_item_t        out_item
);
	import b2da_pkg::*;

	logic [NUM_DIGITS-1:0] valid_s;
	logic [NUM_DIGITS-1:0] started_s;
	logic [VAL_W-1:0]      rem_s  [NUM_DIGITS];
	digits_t               dig_s  [NUM_DIGITS];
	logic [IDX_W-1:0]      lead_s [NUM_DIGITS];
	logic [NUM_DIGITS:0]   rdy;

	// a stage loads when it is empty or its contents move on
	always_comb begin
		rdy[NUM_DIGITS] = out_ready;
		for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
			rdy[k] = !valid_s[k] || rdy[k+1];
		end
	end

	assign in_ready         = rdy[0];
	assign out_valid        = valid_s[NUM_DIGITS-1];
	assign out_item.digits  = dig_s[NUM_DIGITS-1];
	assign out_item.lead    = lead_s[NUM_DIGITS-1];

	for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_stage
		logic             src_valid;
		logic [VAL_W-1:0] src_rem;
		digits_t          src_dig;
		logic [IDX_W-1:0] src_lead;
		logic             src_started;
		logic [DIGIT_W-1:0] d;
		logic [MUL_W-1:0] sub;
		logic [VAL_W-1:0] rem_d;
		digits_t          dig_d;
		logic [IDX_W-1:0] lead_d;
		logic             started_d;

		if (k == 0) begin : g_first
			assign src_valid   = in_valid;
			assign src_rem     = value;
			assign src_dig     = '0;
			assign src_lead    = LAST_IDX;
			assign src_started = 1'b0;
		end else begin : g_next
			assign src_valid   = valid_s[k-1];
			assign src_rem     = rem_s[k-1];
			assign src_dig     = dig_s[k-1];
			assign src_lead    = lead_s[k-1];
			assign src_started = started_s[k-1];
		end

		// largest multiple of this power that fits, then subtract it
		always_comb begin
			d   = '0;
			sub = '0;
			for (int m = 1; m <= MAX_MULT; m++) begin
				if (MUL_W'(src_rem) >= pow10_mult(k, m)) begin
					d   = DIGIT_W'(m);
					sub = pow10_mult(k, m);
				end
			end
			rem_d    = src_rem - sub[VAL_W-1:0];
			dig_d    = src_dig;
			dig_d[k] = d;
			lead_d    = src_lead;
			started_d = src_started;
			if (!src_started && d != '0) begin
				lead_d    = IDX_W'(k);
				started_d = 1'b1;
			end
		end

		// stage valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				valid_s[k] <= src_valid;
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			if (rdy[k] && src_valid) begin
				rem_s[k]     <= rem_d;
				dig_s[k]     <= dig_d;
				lead_s[k]    <= lead_d;
				started_s[k] <= started_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/b2da_serializer.sv
// emits the digits of one converted number as ascii words, one per cycle while char_ready is high
`default_nettype none

module b2da_serializer (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          item_valid,
	output logic                         item_ready,
	input  b2da_pkg::b2da_item_t         item,
	output logic                         char_valid,
	input  wire                          char_ready,
	output logic [b2da_pkg::CHAR_W-1:0]  digit_char,
	output logic                         last
);
	import b2da_pkg::*;

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	b2da_item_t       item_q;

	// current word comes straight from the held digits
	assign char_valid = busy_q;
	assign last       = (idx_q == LAST_IDX);
	assign digit_char = CHAR_ZERO + CHAR_W'(item_q.digits[idx_q]);
	assign item_ready = !busy_q || (char_ready && last);

	// digit pointer and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (item_valid && item_ready) begin
			busy_q <= 1'b1;
			idx_q  <= item.lead;
		end else if (char_valid && char_ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// held digits
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
	end

	// pointer never runs before the leading digit or past the last one
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= LAST_IDX && idx_q >= item_q.lead))
		else $error("digit pointer out of range");

	// the leading digit is nonzero except for a lone zero
	a_lead_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && idx_q == item_q.lead && item_q.lead != LAST_IDX)
		|-> (digit_char != CHAR_ZERO))
		else $error("leading zero emitted");

	// a taken word that is not the last moves to the next digit
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && char_ready && !last) |=> (busy_q && idx_q == $past(idx_q) + 1'b1))
		else $error("digit pointer did not advance");

	// a new number is only taken when nothing is pending or the last word leaves
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && busy_q) |-> (char_ready && last))
		else $error("number loaded over pending digits");

endmodule

`default_nettype wire

// File: rtl/binary_to_decimal_ascii.sv
// top level of the 32-bit binary to decimal ascii converter
//
// Input channel item_valid/item_ready carries one 32-bit unsigned value per word.
// Output channel char_valid/char_ready carries one ascii digit ('0' to '9') per
// word, most significant first, leading zeros dropped; last marks the final
// digit. A zero value gives the single word '0' with last set.
// Path: an accepted value passes through the ten digit stages, the first loaded
// at the accepting edge, and then into the serializer, which shows its first digit.
// Throughput: a number of n digits takes n output words, one to ten; the
// serializer's single output word per cycle, while char_ready is high, sets
// the rate. The pipeline keeps taking values until all ten stages are full.
// Reset clears all valid bits and the serializer; no partial output survives.
// When the receiver holds char_ready low the current word holds and the
// pipeline fills up behind it, then item_ready drops; nothing is lost.
`default_nettype none

module binary_to_decimal_ascii (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          item_valid,
	output logic                         item_ready,
	input  wire [b2da_pkg::VAL_W-1:0]    value,
	output logic                         char_valid,
	input  wire                          char_ready,
	output logic [b2da_pkg::CHAR_W-1:0]  digit_char,
	output logic                         last
);
	import b2da_pkg::*;

	logic       pipe_valid;
	logic       pipe_ready;
	b2da_item_t pipe_item;

	// digit extraction
	b2da_digit_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_ready  (item_ready),
		.value     (value),
		.out_valid (pipe_valid),
		.out_ready (pipe_ready),
		.out_item  (pipe_item)
	);

	// character output
	b2da_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pipe_valid),
		.item_ready (pipe_ready),
		.item       (pipe_item),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

`default_nettype wire
